// ===== design/rmf_pkg.sv =====
// Shared types and constants for the running median filter.
`timescale 1ns / 1ps

package rmf_pkg;

   localparam int MAX_WINDOW  = 31;
   localparam int SAMPLE_BITS = 16;
   localparam int HALF_BITS   = 4;
   localparam int HALF_MAX    = (MAX_WINDOW - 1) / 2;
   localparam int HALF_RESET  = 2;
   localparam int INDEX_BITS  = $clog2(MAX_WINDOW);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [HALF_BITS-1:0]          half_type;
   typedef logic [INDEX_BITS-1:0]         index_type;

   // Broadcast to every pool cell and the history line.
   typedef struct packed {
      logic       step;
      logic       fill;
      sample_type sample;
      sample_type oldest;
   } cell_ctrl_type;

   // Where a cell sits relative to the window in use.
   typedef struct packed {
      logic active;
      logic is_last;
   } cell_pos_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      sample_type value;
      logic       rm;
      logic       ins;
      logic       ge_x;
   } cell_link_type;

endpackage

// ===== design/rmf_history.sv =====
// Delay line of recent samples with a tap at the oldest sample of the window.
`timescale 1ns / 1ps

module rmf_history (
   input  logic                  clock,
   input  logic                  step,
   input  logic                  fill,
   input  rmf_pkg::sample_type   sample,
   input  rmf_pkg::index_type    last_idx,
   output rmf_pkg::sample_type   oldest
);
   import rmf_pkg::*;

   sample_type hist_ff [MAX_WINDOW];

   always_ff @(posedge clock) begin
      if (step) begin
         hist_ff[0] <= sample;
         for (int i = 1; i < MAX_WINDOW; i++) begin
            if (fill) begin
               hist_ff[i] <= sample;
            end else begin
               hist_ff[i] <= hist_ff[i-1];
            end
         end
      end
   end

   assign oldest = hist_ff[last_idx];

endmodule

// ===== design/rmf_cell.sv =====
// One entry of the sorted pool: removes the oldest value and inserts the new one in order.
`timescale 1ns / 1ps

module rmf_cell (
   input  logic                   clock,
   input  rmf_pkg::cell_ctrl_type ctrl,
   input  rmf_pkg::cell_pos_type  pos,
   input  rmf_pkg::cell_link_type left,
   input  rmf_pkg::cell_link_type right,
   output rmf_pkg::cell_link_type link,
   output rmf_pkg::sample_type    next_value
);
   import rmf_pkg::*;

   sample_type value_ff;
   sample_type value_in;
   sample_type after_rm_self;
   sample_type after_rm_left;
   logic       ge_old;
   logic       ge_x;
   logic       rm;
   logic       ge_x_after;
   logic       ins;

   // Since the pool is sorted, the flags rise once along the chain, so the
   // first entry not below a value is where a neighbor's flag differs.
   always_comb begin
      ge_old        = value_ff >= ctrl.oldest;
      ge_x          = value_ff >= ctrl.sample;
      rm            = ge_old || pos.is_last;
      ge_x_after    = rm ? right.ge_x : ge_x;
      ins           = ge_x_after || pos.is_last;
      after_rm_self = rm ? right.value : value_ff;
      after_rm_left = left.rm ? value_ff : left.value;
      if (ins) begin
         value_in = left.ins ? after_rm_left : ctrl.sample;
      end else begin
         value_in = after_rm_self;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         if (ctrl.fill) begin
            value_ff <= ctrl.sample;
         end else if (pos.active) begin
            value_ff <= value_in;
         end
      end
   end

   assign link.value = value_ff;
   assign link.rm    = rm;
   assign link.ins   = ins;
   assign link.ge_x  = ge_x;
   assign next_value = value_in;

endmodule

// ===== design/running_median_filter.sv =====
// Top level of the running median filter: pool cells, history line and handshakes.
`timescale 1ns / 1ps

// The filter takes one sample per clock and returns the median of the last
// 2h+1 samples in the next cycle on the rsp channel; h comes from the csr port
// (0 is taken as 1). The whole window update is one compare-and-shift pass
// through a row of 31 pool cells, so one beat per cycle is sustained while
// rsp_stall is low. A set restart flag, the first sample after reset and the
// first sample after a csr write all fill the window with that sample, whose
// median is the sample itself. Write the csr only while no beat is in flight.
module running_median_filter (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rmf_pkg::sample_type req_sample,
   input  logic                req_restart,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rmf_pkg::sample_type rsp_median,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  rmf_pkg::half_type   csr_window_half
);
   import rmf_pkg::*;

   half_type      window_half_ff;
   logic          primed_ff;
   logic          rsp_valid_ff;
   sample_type    rsp_median_ff;
   sample_type    rsp_median_in;
   half_type      half_use;
   index_type     last_idx;
   index_type     mid_idx;
   logic          step;
   cell_ctrl_type ctrl;
   sample_type    oldest;
   cell_pos_type  pos        [MAX_WINDOW];
   cell_link_type cell_link  [MAX_WINDOW];
   cell_link_type left_link  [MAX_WINDOW];
   cell_link_type right_link [MAX_WINDOW];
   sample_type    next_value [MAX_WINDOW];

   always_comb begin
      if (window_half_ff == '0) begin
         half_use = half_type'(1);
      end else if (32'(window_half_ff) > HALF_MAX) begin
         half_use = half_type'(HALF_MAX);
      end else begin
         half_use = window_half_ff;
      end
      mid_idx  = index_type'(half_use);
      last_idx = index_type'(half_use) << 1;
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign step      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign ctrl.step   = step;
   assign ctrl.fill   = req_restart || !primed_ff;
   assign ctrl.sample = req_sample;
   assign ctrl.oldest = oldest;

   rmf_history u_history (
      .clock    (clock),
      .step     (step),
      .fill     (ctrl.fill),
      .sample   (req_sample),
      .last_idx (last_idx),
      .oldest   (oldest)
   );

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      assign pos[i].active  = index_type'(i) <= last_idx;
      assign pos[i].is_last = index_type'(i) == last_idx;

      if (i == 0) begin : g_first
         assign left_link[i] = '{value: req_sample, rm: 1'b0, ins: 1'b0, ge_x: 1'b0};
      end else begin : g_inner_left
         assign left_link[i] = cell_link[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_last
         assign right_link[i] = '0;
      end else begin : g_inner_right
         assign right_link[i] = cell_link[i+1];
      end

      rmf_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos        (pos[i]),
         .left       (left_link[i]),
         .right      (right_link[i]),
         .link       (cell_link[i]),
         .next_value (next_value[i])
      );
   end

   assign rsp_median_in = ctrl.fill ? req_sample : next_value[mid_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         window_half_ff <= half_type'(HALF_RESET);
         primed_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            window_half_ff <= csr_window_half;
            primed_ff      <= 1'b0;
         end else if (step) begin
            primed_ff <= 1'b1;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_median_ff <= rsp_median_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule

// ===== test/running_median_filter_tb.sv =====
// Testbench for the running median filter: random traffic checked against a sorted window.
`timescale 1ns / 1ps

module running_median_filter_tb;
   import rmf_pkg::*;

   typedef struct packed {
      sample_type sample;
      logic       restart;
   } sample_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   sample_type req_sample = '0;
   logic       req_restart = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sample_type rsp_median;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   half_type   csr_window_half = '0;

   // Predictor state: the window in arrival order and the same values sorted.
   sample_type window_ring [MAX_WINDOW];
   sample_type window_sorted [MAX_WINDOW];
   int         ring_head = 0;
   logic       window_live = 1'b0;
   half_type   half_setting = half_type'(HALF_RESET);

   sample_beat_type sample_queue [$];
   sample_type      median_expected [$];
   sample_type      median_want;
   sample_type      last_sample = '0;
   logic            req_beat_done = 1'b0;
   logic            idle_on = 1'b1;
   int              req_gap = 0;
   int              stall_left = 0;
   int              error_count = 0;
   int              half_plan [8] = '{0, 15, 1, 7, -1, 14, -1, 3};

   running_median_filter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_median      (rsp_median),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_window_half (csr_window_half)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   // Slides the window by one sample and returns the middle of the sorted copy.
   function automatic sample_type filter_step(input sample_type x, input logic restart);
      int half;
      int span;
      int slot;
      int p;
      sample_type oldest;
      half = (half_setting == 0) ? 1 : int'(half_setting);
      if (half > HALF_MAX) begin
         half = HALF_MAX;
      end
      span = 2 * half + 1;
      if (restart || !window_live) begin
         for (int i = 0; i < span; i++) begin
            window_ring[i] = x;
            window_sorted[i] = x;
         end
         ring_head = 0;
         window_live = 1'b1;
      end
      slot = (ring_head >= span) ? 0 : ring_head;
      oldest = window_ring[slot];
      // Drop the first sorted entry that is not below the oldest sample.
      p = span - 1;
      for (int i = 0; i < span; i++) begin
         if (window_sorted[i] >= oldest) begin
            p = i;
            break;
         end
      end
      for (int i = p; i + 1 < span; i++) begin
         window_sorted[i] = window_sorted[i + 1];
      end
      // The new sample goes in front of any equal entries.
      p = span - 1;
      for (int i = 0; i + 1 < span; i++) begin
         if (window_sorted[i] >= x) begin
            p = i;
            break;
         end
      end
      for (int i = span - 1; i > p; i--) begin
         window_sorted[i] = window_sorted[i - 1];
      end
      window_sorted[p] = x;
      window_ring[slot] = x;
      slot++;
      ring_head = (slot >= span) ? 0 : slot;
      return window_sorted[half];
   endfunction

   task automatic add_item(input int value, input logic restart);
      sample_beat_type beat;
      beat.sample = sample_type'(value);
      beat.restart = restart;
      sample_queue = {sample_queue, beat};
      last_sample = beat.sample;
   endtask

   // Mix of full-range values, tight clusters full of duplicates, extremes, slow drifts and repeats.
   task automatic queue_random(input int count);
      int kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3: begin
               add_item(int'(sample_type'($urandom)), $urandom_range(0, 39) == 0);
            end
            4, 5, 6: begin
               add_item(int'($urandom_range(0, 6)) - 3, $urandom_range(0, 39) == 0);
            end
            7: begin
               add_item($urandom_range(0, 1) ? 32767 : -32768, $urandom_range(0, 39) == 0);
            end
            8: begin
               add_item(int'(sample_type'(last_sample + sample_type'($urandom_range(0, 64))
                  - sample_type'(32))), $urandom_range(0, 39) == 0);
            end
            default: begin
               add_item(int'(last_sample), $urandom_range(0, 39) == 0);
            end
         endcase
      end
   endtask

   // Returns once every queued sample has been sent and every median has come back.
   task automatic wait_drained;
      do begin
         @(posedge clock);
      end while (sample_queue.size() != 0 || req_valid || median_expected.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_window_half(input half_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_window_half <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Input driver: a new beat is presented only after the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_done) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            sample_beat_type beat;
            beat = sample_queue.pop_front();
            req_valid <= 1'b1;
            req_sample <= beat.sample;
            req_restart <= beat.restart;
            if (idle_on && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(1, 7);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure in bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Accepted beats feed the predictor; a register write restarts the window.
   always @(posedge clock) begin
      if (reset) begin
         req_beat_done <= 1'b0;
      end else begin
         req_beat_done <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            median_expected = {median_expected, filter_step(req_sample, req_restart)};
         end
         if (csr_valid && csr_ready) begin
            half_setting = csr_window_half;
            window_live = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (median_expected.size() == 0) begin
            report_mismatch($sformatf("median %0d with no sample pending", rsp_median));
         end else begin
            median_want = median_expected.pop_front();
            if (rsp_median !== median_want) begin
               report_mismatch($sformatf("median got %0d, want %0d", rsp_median,
                  median_want));
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      half_type next_half;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed beats at the reset width: the first one has no restart flag.
      add_item(4660, 1'b0);
      add_item(32767, 1'b0);
      add_item(-32768, 1'b0);
      add_item(0, 1'b0);
      add_item(-1, 1'b0);
      add_item(1, 1'b0);
      add_item(32767, 1'b0);
      add_item(32767, 1'b0);
      add_item(-32768, 1'b0);
      add_item(5, 1'b0);
      add_item(5, 1'b0);
      add_item(5, 1'b0);
      add_item(5, 1'b0);
      add_item(-32768, 1'b1);
      add_item(7, 1'b0);
      add_item(-7, 1'b0);
      add_item(100, 1'b0);
      add_item(100, 1'b0);
      add_item(100, 1'b0);
      add_item(-100, 1'b0);
      add_item(32767, 1'b1);
      add_item(0, 1'b0);
      add_item(0, 1'b0);
      add_item(-21846, 1'b0);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         if (half_plan[ph] < 0) begin
            next_half = half_type'($urandom_range(0, 15));
         end else begin
            next_half = half_type'(half_plan[ph]);
         end
         idle_on = (ph % 3 != 2) && (ph != 7);
         write_window_half(next_half);
         queue_random(120);
         // The sender stops here until every median is back, then carries on.
         wait_drained();
         queue_random(ph == 7 ? 150 : 110);
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (median_expected.size() != 0) begin
         report_mismatch($sformatf("%0d medians never arrived", median_expected.size()));
      end
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
